[hw/rtl/timeslice_binned_hit_counter_unit_macros.svh]
// Assertion macros for the timeslice binned hit counter.
// Used by the top level; needs clk and rst_n in scope.
`ifndef TIMESLICE_BINNED_HIT_COUNTER_UNIT_MACROS_SVH
`define TIMESLICE_BINNED_HIT_COUNTER_UNIT_MACROS_SVH

// same-cycle implication
`define TBHC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TBHC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/tbhc_pkg.sv]
// Shared types and constants for the timeslice binned hit counter.
// No dependencies.
`timescale 1ns / 1ps

package tbhc_pkg;

  localparam int SLICE_W   = 40;
  localparam int BW_W      = 32;
  localparam int OFS_W     = 32;
  localparam int TIME_W    = 62;
  localparam int CHG_W     = 8;
  localparam int ADDR_W    = 32;
  localparam int OUT_CNT_W = 16;
  localparam int BIN_IDX_W = 6;
  localparam int DIFF_W    = 64;
  localparam int KINDS     = 7;
  localparam int NUM_DET   = 5;
  localparam int DET_W     = 3;
  localparam int CMD_W     = 2;
  localparam int PADDR_W   = 6;
  localparam int PDATA_W   = 64;
  localparam int BOARD_BIT = 10;

  localparam int DEF_NUM_BINS    = 64;
  localparam int DEF_COUNT_WIDTH = 16;

  localparam int K_T0   = 0;
  localparam int K_STS  = 1;
  localparam int K_STS0 = 2;
  localparam int K_STS1 = 3;
  localparam int K_MUCH = 4;
  localparam int K_TOF  = 5;
  localparam int K_RICH = 6;

  localparam logic [CHG_W-1:0] TOF_PULSE_LOW  = 8'd92;
  localparam logic [CHG_W-1:0] TOF_PULSE_HIGH = 8'd96;

  localparam logic [SLICE_W-1:0] RST_SLICE_LEN = 40'd102400;
  localparam logic [BW_W-1:0]    RST_BIN_W     = 32'd1600;
  localparam logic [CHG_W-1:0]   RST_T0_LO     = 8'd90;
  localparam logic [CHG_W-1:0]   RST_T0_HI     = 8'd100;

  typedef enum logic [CMD_W-1:0] {
    CMD_START = 2'd0,
    CMD_HIT   = 2'd1,
    CMD_END   = 2'd2
  } cmd_e;

  typedef enum logic [DET_W-1:0] {
    DET_T0   = 3'd0,
    DET_STS  = 3'd1,
    DET_MUCH = 3'd2,
    DET_TOF  = 3'd3,
    DET_RICH = 3'd4
  } det_e;

  typedef enum logic [2:0] {
    REG_SLICE_LEN = 3'd0,
    REG_BIN_W     = 3'd1,
    REG_STS_OFS   = 3'd2,
    REG_MUCH_OFS  = 3'd3,
    REG_TOF_OFS   = 3'd4,
    REG_RICH_OFS  = 3'd5,
    REG_T0_LO     = 3'd6,
    REG_T0_HI     = 3'd7
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_DIV,
    ST_MOD,
    ST_ERD,
    ST_ELOAD,
    ST_EOUT
  } state_t;

  typedef struct packed {
    logic [SLICE_W-1:0]      slice_len;
    logic [BW_W-1:0]         bin_w;
    logic signed [OFS_W-1:0] sts_ofs;
    logic signed [OFS_W-1:0] much_ofs;
    logic signed [OFS_W-1:0] tof_ofs;
    logic signed [OFS_W-1:0] rich_ofs;
    logic [CHG_W-1:0]        t0_lo;
    logic [CHG_W-1:0]        t0_hi;
  } cfg_t;

  typedef struct packed {
    logic                 done;
    logic                 in_range;
    logic [BIN_IDX_W-1:0] bin;
  } div_res_t;

endpackage

[hw/rtl/tbhc_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module tbhc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/tbhc_cfg.sv]
// APB-style configuration registers for the timeslice binned hit counter.
// Depends on tbhc_pkg.
`timescale 1ns / 1ps

module tbhc_cfg
  import tbhc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  cfg_t     cfg_r;
  reg_idx_e idx;
  logic     wr;

  assign idx    = reg_idx_e'(paddr[5:3]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.slice_len <= RST_SLICE_LEN;
      cfg_r.bin_w     <= RST_BIN_W;
      cfg_r.sts_ofs   <= '0;
      cfg_r.much_ofs  <= '0;
      cfg_r.tof_ofs   <= '0;
      cfg_r.rich_ofs  <= '0;
      cfg_r.t0_lo     <= RST_T0_LO;
      cfg_r.t0_hi     <= RST_T0_HI;
    end else if (wr) begin
      unique case (idx)
        REG_SLICE_LEN: cfg_r.slice_len <= pwdata[SLICE_W-1:0];
        REG_BIN_W:     cfg_r.bin_w     <= pwdata[BW_W-1:0];
        REG_STS_OFS:   cfg_r.sts_ofs   <= pwdata[OFS_W-1:0];
        REG_MUCH_OFS:  cfg_r.much_ofs  <= pwdata[OFS_W-1:0];
        REG_TOF_OFS:   cfg_r.tof_ofs   <= pwdata[OFS_W-1:0];
        REG_RICH_OFS:  cfg_r.rich_ofs  <= pwdata[OFS_W-1:0];
        REG_T0_LO:     cfg_r.t0_lo     <= pwdata[CHG_W-1:0];
        REG_T0_HI:     cfg_r.t0_hi     <= pwdata[CHG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_SLICE_LEN: prdata = PDATA_W'(cfg_r.slice_len);
      REG_BIN_W:     prdata = PDATA_W'(cfg_r.bin_w);
      REG_STS_OFS:   prdata = PDATA_W'(unsigned'(cfg_r.sts_ofs));
      REG_MUCH_OFS:  prdata = PDATA_W'(unsigned'(cfg_r.much_ofs));
      REG_TOF_OFS:   prdata = PDATA_W'(unsigned'(cfg_r.tof_ofs));
      REG_RICH_OFS:  prdata = PDATA_W'(unsigned'(cfg_r.rich_ofs));
      REG_T0_LO:     prdata = PDATA_W'(cfg_r.t0_lo);
      REG_T0_HI:     prdata = PDATA_W'(cfg_r.t0_hi);
      default:       prdata = '0;
    endcase
  end

endmodule

[hw/rtl/tbhc_bindiv.sv]
// Iterative restoring divider giving the bin index of a slice time.
// One quotient bit per cycle; depends on tbhc_pkg.
`timescale 1ns / 1ps

module tbhc_bindiv
  import tbhc_pkg::*;
#(
  parameter int NUM_BINS = DEF_NUM_BINS,
  localparam int QW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1,
  localparam int SW = (QW > 1) ? $clog2(QW) : 1,
  localparam int DW = SLICE_W + QW
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [SLICE_W-1:0] t,
  input  logic [BW_W-1:0]    bw,
  output div_res_t           res
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic              inr_r, inr_nxt;
  logic [SW-1:0]     step_r, step_nxt;
  logic [DW-1:0]     rem_r, rem_nxt;
  logic [DW-1:0]     dsh_r, dsh_nxt;
  logic [QW-1:0]     q_r, q_nxt;
  logic              ge;

  assign ge = rem_r >= dsh_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    inr_nxt  = inr_r;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    q_nxt    = q_r;
    if (start) begin
      if (DW'(t) >= (DW'(bw) << QW)) begin
        done_nxt = 1'b1;
        inr_nxt  = 1'b0;
      end else begin
        busy_nxt = 1'b1;
        rem_nxt  = DW'(t);
        dsh_nxt  = DW'(bw) << (QW - 1);
        step_nxt = SW'(QW - 1);
        q_nxt    = '0;
      end
    end else if (busy_r) begin
      if (ge) begin
        rem_nxt = rem_r - dsh_r;
      end
      q_nxt   = (q_r << 1) | QW'(ge);
      dsh_nxt = dsh_r >> 1;
      if (step_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        inr_nxt  = 32'(q_nxt) < NUM_BINS;
      end else begin
        step_nxt = step_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      inr_r  <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      inr_r  <= inr_nxt;
    end
    step_r <= step_nxt;
    rem_r  <= rem_nxt;
    dsh_r  <= dsh_nxt;
    q_r    <= q_nxt;
  end

  assign res.done     = done_r;
  assign res.in_range = inr_r;
  assign res.bin      = BIN_IDX_W'(q_r);

endmodule

[hw/rtl/timeslice_binned_hit_counter_unit.sv]
// Top level of the timeslice binned hit counter.
// Depends on tbhc_pkg, tbhc_cfg, tbhc_bindiv, tbhc_ram and the macros header.
//
// Usage:
//   Input channel (in_*): one beat per command. Start latches the slice start
//   time and clears all bin counters and detector stop flags. A hit is taken
//   in idle and checked in calc; it ends there when rejected, stopping or with
//   zero bin width. Else the divider works out its bin one quotient bit at a
//   time; a hit whose bin lies past the last one ends when the divider is done,
//   and a counted one reads its counter row then and writes it back in mod. End
//   is accepted in idle, then each record is read, loaded and held until
//   out_ready (erd, eload, eout), NUM_BINS records in all; out_last_bin marks the last one.
//   Counters live in one RAM row per bin (7 counters side by side); a row is
//   read, incremented and written back, one hit at a time. Per-row valid
//   flops clear the whole table at start, so no clearing pass is needed.
//   Result channel (out_*): a record stays on the port until out_ready; the
//   block takes no new beat until the last record of an end has gone.
//   Reset: synchronous, active low; counters read as zero, registers return
//   to their defaults, and the block comes out of reset idle and ready.
//   Configuration: APB-style, 64-bit data, register i at byte address 8*i.
`timescale 1ns / 1ps
`include "timeslice_binned_hit_counter_unit_macros.svh"

module timeslice_binned_hit_counter_unit
  import tbhc_pkg::*;
#(
  parameter int NUM_BINS    = DEF_NUM_BINS,
  parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [PDATA_W-1:0]   pwdata,
  output logic [PDATA_W-1:0]   prdata,
  output logic                 pready,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [CMD_W-1:0]     in_command,
  input  logic [DET_W-1:0]     in_detector,
  input  logic [TIME_W-1:0]    in_time_ns,
  input  logic [CHG_W-1:0]     in_charge,
  input  logic [ADDR_W-1:0]    in_address,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [BIN_IDX_W-1:0] out_bin_index,
  output logic [OUT_CNT_W-1:0] out_t0_hits,
  output logic [OUT_CNT_W-1:0] out_sts_hits,
  output logic [OUT_CNT_W-1:0] out_sts_board0_hits,
  output logic [OUT_CNT_W-1:0] out_sts_board1_hits,
  output logic [OUT_CNT_W-1:0] out_much_hits,
  output logic [OUT_CNT_W-1:0] out_tof_hits,
  output logic [OUT_CNT_W-1:0] out_rich_hits,
  output logic                 out_last_bin
);

  localparam int QW    = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int ROW_W = KINDS * COUNT_WIDTH;

  cfg_t     cfg;
  div_res_t div_res;

  state_t                state_r, state_nxt;
  logic [DET_W-1:0]      det_r;
  logic [TIME_W-1:0]     time_r;
  logic [CHG_W-1:0]      chg_r;
  logic                  board_r;
  logic [TIME_W-1:0]     slice_start_r, slice_start_nxt;
  logic [NUM_DET-1:0]    stopped_r, stopped_nxt;
  logic [NUM_BINS-1:0]   row_vld_r, row_vld_nxt;
  logic                  rd_vld_r;
  logic [QW-1:0]         bin_r, bin_nxt;
  logic [QW-1:0]         emit_r, emit_nxt;
  logic [OUT_CNT_W-1:0]  out_cnt_r [KINDS];
  logic                  load_out;
  logic                  accept;

  logic signed [OFS_W-1:0]  ofs;
  logic signed [DIFF_W-1:0] diff;
  logic                     skip, over;
  logic                     div_start;

  logic             ram_we, ram_re;
  logic [QW-1:0]    ram_raddr;
  logic [ROW_W-1:0] ram_rdata, ram_wdata;
  logic [KINDS-1:0] inc;

  tbhc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tbhc_bindiv #(.NUM_BINS(NUM_BINS)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .t     (diff[SLICE_W-1:0]),
    .bw    (cfg.bin_w),
    .res   (div_res)
  );

  tbhc_ram #(.WIDTH(ROW_W), .DEPTH(NUM_BINS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (bin_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign accept = in_valid && in_ready;

  always_comb begin
    unique case (det_e'(det_r))
      DET_STS:  ofs = cfg.sts_ofs;
      DET_MUCH: ofs = cfg.much_ofs;
      DET_TOF:  ofs = cfg.tof_ofs;
      DET_RICH: ofs = cfg.rich_ofs;
      default:  ofs = '0;
    endcase
  end

  assign diff = $signed({2'b00, time_r}) - $signed({2'b00, slice_start_r})
              - DIFF_W'(ofs);

  always_comb begin
    skip = 1'b0;
    if (det_r > DET_RICH) begin
      skip = 1'b1;
    end else if (stopped_r[det_r]) begin
      skip = 1'b1;
    end else if (det_r == DET_T0 && cfg.t0_lo < chg_r && chg_r < cfg.t0_hi) begin
      skip = 1'b1;
    end else if (det_r == DET_TOF && TOF_PULSE_LOW < chg_r && chg_r < TOF_PULSE_HIGH) begin
      skip = 1'b1;
    end
    if (diff[DIFF_W-1]) begin
      skip = 1'b1;
    end
  end

  assign over = (diff[DIFF_W-1:SLICE_W] != '0) || (diff[SLICE_W-1:0] >= cfg.slice_len);

  always_comb begin
    inc = '0;
    unique case (det_e'(det_r))
      DET_T0:   inc[K_T0] = 1'b1;
      DET_STS: begin
        inc[K_STS] = 1'b1;
        if (board_r) inc[K_STS1] = 1'b1;
        else         inc[K_STS0] = 1'b1;
      end
      DET_MUCH: inc[K_MUCH] = 1'b1;
      DET_TOF:  inc[K_TOF]  = 1'b1;
      DET_RICH: inc[K_RICH] = 1'b1;
      default:  inc = '0;
    endcase
  end

  always_comb begin
    logic [COUNT_WIDTH-1:0] c;
    for (int k = 0; k < KINDS; k++) begin
      c = rd_vld_r ? ram_rdata[k*COUNT_WIDTH +: COUNT_WIDTH] : '0;
      if (inc[k] && c != '1) begin
        c = c + 1'b1;
      end
      ram_wdata[k*COUNT_WIDTH +: COUNT_WIDTH] = c;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    slice_start_nxt = slice_start_r;
    stopped_nxt     = stopped_r;
    row_vld_nxt     = row_vld_r;
    bin_nxt         = bin_r;
    emit_nxt        = emit_r;
    in_ready        = 1'b0;
    out_valid       = 1'b0;
    div_start       = 1'b0;
    ram_we          = 1'b0;
    ram_re          = 1'b0;
    ram_raddr       = emit_r;
    load_out        = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (cmd_e'(in_command))
            CMD_START: begin
              slice_start_nxt = in_time_ns;
              stopped_nxt     = '0;
              row_vld_nxt     = '0;
            end
            CMD_HIT: state_nxt = ST_CALC;
            CMD_END: begin
              emit_nxt  = '0;
              state_nxt = ST_ERD;
            end
            default: ;
          endcase
        end
      end
      ST_CALC: begin
        if (skip) begin
          state_nxt = ST_IDLE;
        end else if (over) begin
          stopped_nxt[det_r] = 1'b1;
          state_nxt = ST_IDLE;
        end else if (cfg.bin_w == '0) begin
          state_nxt = ST_IDLE;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_res.done) begin
          if (div_res.in_range) begin
            bin_nxt   = QW'(div_res.bin);
            ram_re    = 1'b1;
            ram_raddr = QW'(div_res.bin);
            state_nxt = ST_MOD;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_MOD: begin
        ram_we             = 1'b1;
        row_vld_nxt[bin_r] = 1'b1;
        state_nxt          = ST_IDLE;
      end
      ST_ERD: begin
        ram_re    = 1'b1;
        state_nxt = ST_ELOAD;
      end
      ST_ELOAD: begin
        load_out  = 1'b1;
        state_nxt = ST_EOUT;
      end
      ST_EOUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (32'(emit_r) == NUM_BINS - 1) begin
            emit_nxt  = '0;
            state_nxt = ST_IDLE;
          end else begin
            emit_nxt  = emit_r + 1'b1;
            state_nxt = ST_ERD;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      slice_start_r <= '0;
      stopped_r     <= '0;
      row_vld_r     <= '0;
      emit_r        <= '0;
    end else begin
      state_r       <= state_nxt;
      slice_start_r <= slice_start_nxt;
      stopped_r     <= stopped_nxt;
      row_vld_r     <= row_vld_nxt;
      emit_r        <= emit_nxt;
    end
    bin_r <= bin_nxt;
    if (ram_re) begin
      rd_vld_r <= row_vld_r[ram_raddr];
    end
    if (accept) begin
      det_r   <= in_detector;
      time_r  <= in_time_ns;
      chg_r   <= in_charge;
      board_r <= in_address[BOARD_BIT];
    end
    if (load_out) begin
      for (int k = 0; k < KINDS; k++) begin
        out_cnt_r[k] <= rd_vld_r ? OUT_CNT_W'(ram_rdata[k*COUNT_WIDTH +: COUNT_WIDTH]) : '0;
      end
    end
  end

  assign out_bin_index       = BIN_IDX_W'(emit_r);
  assign out_last_bin        = (32'(emit_r) == NUM_BINS - 1);
  assign out_t0_hits         = out_cnt_r[K_T0];
  assign out_sts_hits        = out_cnt_r[K_STS];
  assign out_sts_board0_hits = out_cnt_r[K_STS0];
  assign out_sts_board1_hits = out_cnt_r[K_STS1];
  assign out_much_hits       = out_cnt_r[K_MUCH];
  assign out_tof_hits        = out_cnt_r[K_TOF];
  assign out_rich_hits       = out_cnt_r[K_RICH];

  `TBHC_ASSERT_IMP(a_one_side, out_valid, !in_ready, "result and input sides active together")
  `TBHC_ASSERT_NXT(a_start_clears, accept && in_command == CMD_START,
                   row_vld_r == '0 && stopped_r == '0, "start did not clear the slice")
  `TBHC_ASSERT_NXT(a_emit_done, out_valid && out_ready && out_last_bin, in_ready,
                   "block not ready after the last record")
  `TBHC_ASSERT_IMP(a_bin_range, ram_we, 32'(bin_r) < NUM_BINS, "counter write past last bin")

endmodule

[tb/tb_top.sv]
// Self-checking bench for timeslice_binned_hit_counter_unit: directed and random
// commands, an in-bench count predictor and a per-record scoreboard.
// Depends on tbhc_pkg and the RTL top level.
`timescale 1ns / 1ps

module tb_top;
  import tbhc_pkg::*;

  localparam int NBINS = DEF_NUM_BINS;
  localparam int CMAX = (1 << DEF_COUNT_WIDTH) - 1;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [DET_W-1:0] DET_UNUSED = 3'd7;
  localparam int WDOG_LIMIT = 4000;

  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [DET_W-1:0]  det;
    logic [TIME_W-1:0] tns;
    logic [CHG_W-1:0]  chg;
    logic [ADDR_W-1:0] addr;
    bit                sync;
  } beat_t;

  typedef struct {
    logic [BIN_IDX_W-1:0] bin;
    logic [OUT_CNT_W-1:0] cnt[KINDS];
    logic                 last;
  } bin_rec_t;

  logic clk, rst_n;
  logic psel, penable, pwrite, pready;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata, prdata;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [CMD_W-1:0] in_command;
  logic [DET_W-1:0] in_detector;
  logic [TIME_W-1:0] in_time_ns;
  logic [CHG_W-1:0] in_charge;
  logic [ADDR_W-1:0] in_address;
  logic [BIN_IDX_W-1:0] out_bin_index;
  logic [OUT_CNT_W-1:0] out_t0_hits, out_sts_hits, out_sts_board0_hits;
  logic [OUT_CNT_W-1:0] out_sts_board1_hits, out_much_hits, out_tof_hits, out_rich_hits;
  logic out_last_bin;

  timeslice_binned_hit_counter_unit u_dut (.*);

  // predictor state
  logic [SLICE_W-1:0] m_slice_len;
  logic [BW_W-1:0] m_bin_w;
  logic signed [OFS_W-1:0] m_ofs[NUM_DET];
  logic [CHG_W-1:0] m_t0_lo, m_t0_hi;
  int unsigned m_counts[NBINS][KINDS];
  logic [NUM_DET-1:0] m_stopped;
  logic [TIME_W-1:0] m_start;

  beat_t pending[$];
  beat_t cur;
  bin_rec_t bins_due[$];
  int errors = 0;
  int mode = 0;
  int hold_req = 0;
  int hold_cnt = 0;
  int quiet = 0;
  bit apb_busy = 0;
  logic [TIME_W-1:0] g_start;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  task automatic report(string what, longint unsigned want, longint unsigned got);
    $display("mismatch %s: expected %0d got %0d at %0t", what, want, got, $realtime);
    errors++;
  endtask

  function automatic void bump(int b, int k);
    if (m_counts[b][k] < CMAX) m_counts[b][k]++;
  endfunction

  function automatic void count_hit(beat_t h);
    longint t;
    longint unsigned b;
    if (h.det > DET_RICH || m_stopped[h.det]) return;
    if (h.det == DET_T0 && m_t0_lo < h.chg && h.chg < m_t0_hi) return;
    if (h.det == DET_TOF && TOF_PULSE_LOW < h.chg && h.chg < TOF_PULSE_HIGH) return;
    t = longint'({2'b00, h.tns}) - longint'({2'b00, m_start});
    if (h.det != DET_T0) t = t - longint'(m_ofs[h.det]);
    if (t < 0) return;
    if (t >= longint'({24'd0, m_slice_len})) begin
      m_stopped[h.det] = 1'b1;
      return;
    end
    if (m_bin_w == 0) return;
    b = longint'(t) / longint'({32'd0, m_bin_w});
    if (b >= NBINS) return;
    case (h.det)
      DET_T0: bump(b, K_T0);
      DET_STS: begin
        bump(b, K_STS);
        bump(b, h.addr[BOARD_BIT] ? K_STS1 : K_STS0);
      end
      DET_MUCH: bump(b, K_MUCH);
      DET_TOF: bump(b, K_TOF);
      default: bump(b, K_RICH);
    endcase
  endfunction

  function automatic void apply_beat(beat_t h);
    bin_rec_t r;
    case (h.cmd)
      CMD_START: begin
        m_start = h.tns;
        m_stopped = '0;
        foreach (m_counts[i, k]) m_counts[i][k] = 0;
      end
      CMD_HIT: count_hit(h);
      CMD_END: begin
        for (int i = 0; i < NBINS; i++) begin
          r.bin = i;
          for (int k = 0; k < KINDS; k++) r.cnt[k] = m_counts[i][k][OUT_CNT_W-1:0];
          r.last = (i == NBINS - 1);
          bins_due.push_back(r);
        end
      end
      default: ;
    endcase
  endfunction

  // sender
  always @(posedge clk) begin
    bit fire;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      fire = in_valid && in_ready;
      if (fire) apply_beat(cur);
      if (!in_valid || fire) begin
        if (pending.size() > 0 && !(pending[0].sync && bins_due.size() > 0) &&
            !(mode == 0 && $urandom_range(99) < 21) &&
            !(mode == 1 && $urandom_range(99) < 85)) begin
          cur = pending.pop_front();
          in_command <= cur.cmd;
          in_detector <= cur.det;
          in_time_ns <= cur.tns;
          in_charge <= cur.chg;
          in_address <= cur.addr;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver ready, with a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready <= 1'b0;
    end else if (hold_req > 0) begin
      hold_cnt <= hold_req;
      hold_req <= 0;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !((mode == 0 && $urandom_range(99) < 85) ||
                     (mode == 1 && $urandom_range(99) < 21));
    end
  end

  // record checker
  always @(posedge clk) begin
    bin_rec_t e;
    logic [OUT_CNT_W-1:0] got[KINDS];
    if (rst_n && out_valid && out_ready) begin
      if (bins_due.size() == 0) begin
        report("unexpected record, bin", 0, out_bin_index);
      end else begin
        e = bins_due.pop_front();
        got = '{out_t0_hits, out_sts_hits, out_sts_board0_hits, out_sts_board1_hits,
                out_much_hits, out_tof_hits, out_rich_hits};
        if (out_bin_index !== e.bin) report("bin_index", e.bin, out_bin_index);
        for (int k = 0; k < KINDS; k++)
          if (got[k] !== e.cnt[k]) report($sformatf("bin %0d kind %0d", e.bin, k),
                                          e.cnt[k], got[k]);
        if (out_last_bin !== e.last) report("last_bin", e.last, out_last_bin);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || apb_busy) begin
      quiet <= 0;
    end else if (quiet >= WDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic push(logic [CMD_W-1:0] c, logic [DET_W-1:0] d, logic [TIME_W-1:0] t,
                      logic [CHG_W-1:0] q, logic [ADDR_W-1:0] a, bit s = 0);
    beat_t b;
    b.cmd = c; b.det = d; b.tns = t; b.chg = q; b.addr = a; b.sync = s;
    pending.push_back(b);
  endtask

  task automatic drain();
    while (pending.size() > 0 || in_valid || bins_due.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic reg_write(reg_idx_e idx, logic [PDATA_W-1:0] v);
    apb_busy = 1;
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= PADDR_W'(idx) << 3; pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0;
    case (idx)
      REG_SLICE_LEN: m_slice_len = v[SLICE_W-1:0];
      REG_BIN_W: m_bin_w = v[BW_W-1:0];
      REG_STS_OFS: m_ofs[DET_STS] = v[OFS_W-1:0];
      REG_MUCH_OFS: m_ofs[DET_MUCH] = v[OFS_W-1:0];
      REG_TOF_OFS: m_ofs[DET_TOF] = v[OFS_W-1:0];
      REG_RICH_OFS: m_ofs[DET_RICH] = v[OFS_W-1:0];
      REG_T0_LO: m_t0_lo = v[CHG_W-1:0];
      default: m_t0_hi = v[CHG_W-1:0];
    endcase
    @(posedge clk);
    apb_busy = 0;
  endtask

  function automatic logic [CHG_W-1:0] rand_charge();
    return ($urandom_range(3) == 0) ? CHG_W'($urandom_range(88, 101)) : CHG_W'($urandom);
  endfunction

  // one slice: start, hits around the window, end; some noise mixed in
  task automatic random_slice(int nhits);
    logic [TIME_W-1:0] t;
    logic [DET_W-1:0] d;
    longint unsigned span;
    g_start = ($urandom_range(3) == 0) ? {$urandom, $urandom} : TIME_W'($urandom);
    push(CMD_START, DET_T0, g_start, $urandom, $urandom, 1);
    span = (m_slice_len > 40'd200000) ? 64'd200000 : m_slice_len;
    span = span + span / 8 + 2;
    for (int i = 0; i < nhits; i++) begin
      d = DET_W'($urandom_range(4));
      t = g_start + TIME_W'($urandom_range(span - 1));
      if (d != DET_T0) t = t + TIME_W'(longint'(m_ofs[d]));
      case ($urandom_range(19))
        0: push(CMD_UNUSED, d, t, $urandom, $urandom);
        1: push(CMD_HIT, DET_W'($urandom_range(7, 5)), t, $urandom, $urandom);
        2: push(CMD_HIT, d, {$urandom, $urandom}, rand_charge(), $urandom);
        3: push(CMD_HIT, d, t - TIME_W'($urandom_range(1, 5000)), rand_charge(), $urandom);
        default: push(CMD_HIT, d, t, rand_charge(), $urandom);
      endcase
    end
    push(CMD_END, DET_T0, $urandom, $urandom, $urandom);
  endtask

  task automatic random_cfg();
    logic [BW_W-1:0] bw;
    bw = BW_W'($urandom_range(1, 3000));
    reg_write(REG_BIN_W, bw);
    reg_write(REG_SLICE_LEN, bw * $urandom_range(40, 70) + $urandom_range(bw));
    reg_write(REG_STS_OFS, {32'd0, 32'($signed($urandom_range(2000)) - 1000)});
    reg_write(REG_MUCH_OFS, {32'd0, 32'($signed($urandom_range(2000)) - 1000)});
    reg_write(REG_TOF_OFS, {32'd0, 32'($signed($urandom_range(2000)) - 1000)});
    reg_write(REG_RICH_OFS, {32'd0, 32'($signed($urandom_range(2000)) - 1000)});
    reg_write(REG_T0_LO, $urandom_range(80, 95));
    reg_write(REG_T0_HI, $urandom_range(90, 110));
  endtask

  initial begin
    rst_n = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_valid = 1'b0; out_ready = 1'b0;
    in_command = CMD_START; in_detector = DET_T0; in_time_ns = '0;
    in_charge = '0; in_address = '0;
    m_slice_len = RST_SLICE_LEN; m_bin_w = RST_BIN_W;
    foreach (m_ofs[i]) m_ofs[i] = '0;
    m_t0_lo = RST_T0_LO; m_t0_hi = RST_T0_HI;
    foreach (m_counts[i, k]) m_counts[i][k] = 0;
    m_stopped = '0; m_start = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset configuration; hits before any start use start zero
    mode = 0;
    push(CMD_HIT, DET_T0, 62'd5, 8'd0, 32'd0);
    push(CMD_HIT, DET_T0, 62'd6, 8'd95, 32'd0);
    push(CMD_HIT, DET_T0, 62'd7, 8'd255, 32'hFFFF_FFFF);
    push(CMD_HIT, DET_STS, 62'd1600, 8'd0, 32'h0000_0400);
    push(CMD_HIT, DET_STS, 62'd1601, 8'd0, 32'hFFFF_FBFF);
    push(CMD_HIT, DET_MUCH, 62'd102399, 8'd0, 32'd0);
    push(CMD_HIT, DET_TOF, 62'd3200, 8'd94, 32'd0);
    push(CMD_HIT, DET_TOF, 62'd3200, 8'd96, 32'd0);
    push(CMD_HIT, DET_RICH, 62'd102400, 8'd0, 32'd0);
    push(CMD_HIT, DET_RICH, 62'd10, 8'd0, 32'd0);
    push(CMD_HIT, DET_UNUSED, 62'd10, 8'd0, 32'd0);
    push(CMD_UNUSED, DET_T0, 62'd10, 8'd0, 32'd0);
    push(CMD_END, DET_T0, 62'd0, 8'd0, 32'd0);
    push(CMD_END, DET_T0, 62'd0, 8'd0, 32'd0);
    push(CMD_START, DET_T0, 62'h3FFF_FFFF_FFFF_FF00, 8'd0, 32'd0, 1);
    push(CMD_HIT, DET_T0, 62'h3FFF_FFFF_FFFF_FFFF, 8'd0, 32'd0);
    push(CMD_HIT, DET_STS, 62'h3FFF_FFFF_FFFF_FEFF, 8'd0, 32'd0);
    push(CMD_HIT, DET_T0, 62'd0, 8'd0, 32'd0);
    push(CMD_END, DET_T0, 62'h3FFF_FFFF_FFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
    drain();
    // long receiver hold-off; the extra end is offered while records wait
    hold_req = 400;
    random_slice(12);
    push(CMD_END, DET_T0, 62'd0, 8'd0, 32'd0);
    random_slice(12);
    drain();

    // zero slice length and zero bin width, extreme offsets and windows
    reg_write(REG_SLICE_LEN, 64'd0);
    reg_write(REG_T0_LO, 64'd0);
    reg_write(REG_T0_HI, 64'd255);
    reg_write(REG_STS_OFS, 64'h0000_0000_8000_0000);
    reg_write(REG_MUCH_OFS, 64'h0000_0000_7FFF_FFFF);
    push(CMD_START, DET_T0, 62'h1_0000_0000, 8'd0, 32'd0);
    push(CMD_HIT, DET_STS, 62'h1_0000_0000, 8'd0, 32'd0);
    push(CMD_HIT, DET_MUCH, 62'h1_7FFF_FFFF, 8'd0, 32'd0);
    push(CMD_HIT, DET_T0, 62'h1_0000_0000, 8'd0, 32'd0);
    push(CMD_END, DET_T0, 62'd0, 8'd0, 32'd0);
    drain();
    reg_write(REG_SLICE_LEN, 64'hFF_FFFF_FFFF);
    reg_write(REG_BIN_W, 64'd0);
    reg_write(REG_TOF_OFS, 64'h0000_0000_8000_0000);
    reg_write(REG_RICH_OFS, 64'h0000_0000_7FFF_FFFF);
    random_slice(10);
    drain();
    reg_write(REG_BIN_W, 64'hFFFF_FFFF);
    random_slice(10);
    drain();

    for (int p = 0; p < 8; p++) begin
      mode = (p < 3) ? 0 : (p < 6) ? 1 : 2;
      random_cfg();
      random_slice($urandom_range(25, 40));
      drain();
    end

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/tbhc_pkg.sv
hw/rtl/tbhc_ram.sv
hw/rtl/tbhc_cfg.sv
hw/rtl/tbhc_bindiv.sv
hw/rtl/timeslice_binned_hit_counter_unit.sv
tb/tb_top.sv
